[rtl/core/scan_polar_to_cartesian_macros.svh]
// assertion macros for the polar to cartesian scan converter
`ifndef SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spc assertion failed");

`endif

[rtl/core/spc_pkg.sv]
// shared constants, tables, types and gain computation for the scan converter
`timescale 1ns / 1ps

package spc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;

	localparam int FRAC_BITS = 20;
	localparam int TABLE_LEN = 24;
	localparam int TBL_IDX_W = 5;

	localparam int RANGE_W  = 16;
	localparam int ANG_IN_W = 16;
	localparam int POINT_W  = 17;
	localparam int K_W      = 30;
	localparam int PROD_W   = RANGE_W + K_W;
	localparam int XY_W     = 39;
	localparam int Z_W      = ANGLE_BITS + 2;
	localparam int CNT_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int SHIFT_UP = (ANGLE_BITS >= ANG_IN_W) ? (ANGLE_BITS - ANG_IN_W) : 0;
	localparam int SHIFT_DN = (ANGLE_BITS < ANG_IN_W) ? (ANG_IN_W - ANGLE_BITS) : 0;
	localparam int HALF_DN  = (1 << SHIFT_DN) >> 1;
	localparam int PH_W     = ANG_IN_W + SHIFT_UP + 1;

	localparam int ATAN_SH   = 32 - ANGLE_BITS;
	localparam int ATAN_HALF = 1 << (ATAN_SH - 1);

	localparam int SCALE_SH = 30 - FRAC_BITS;
	localparam int PT_MAX   = 65535;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = CFG_IDX_W'(1);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic fold;
		logic step;
		logic store;
	} spc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic step_last;
	} spc_sts_t;

	// arctangent of 2^-i, 2^32 per turn
	function automatic logic [31:0] atan_turn32(input logic [TBL_IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// arctangent rounded half up to the working angle resolution
	function automatic logic [Z_W-1:0] atan_step(input logic [CNT_W-1:0] idx);
		logic [32:0] sum;
		logic [32:0] shifted;
		sum     = {1'b0, atan_turn32(TBL_IDX_W'(idx))} + 33'(ATAN_HALF);
		shifted = sum >> ATAN_SH;
		return shifted[Z_W-1:0];
	endfunction

	// inverse cordic gain in q30, evaluated at elaboration
	function automatic logic [63:0] gain_inv_q30();
		logic [63:0] g2;
		logic [63:0] n;
		logic [63:0] root;
		logic [63:0] bitv;
		logic [63:0] g;
		logic [63:0] num;
		logic [63:0] quo;
		logic [64:0] rem;
		int i;
		g2 = 64'd1 << 30;
		for (i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
			g2 = g2 + ((g2 + ((64'd1 << (2 * i)) >> 1)) >> (2 * i));
		end
		// integer square root, floor
		n    = g2 << 30;
		root = 64'd0;
		bitv = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (n >= root + bitv) begin
				n    = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		g = (root == 64'd0) ? 64'd1 : root;
		// shift-subtract quotient, rounded half up
		num = (64'd1 << 60) + (g >> 1);
		rem = 65'd0;
		quo = 64'd0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, g}) begin
				rem    = rem - {1'b0, g};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	localparam logic [63:0]    GAIN_FULL = gain_inv_q30();
	localparam logic [K_W-1:0] GAIN_K    = GAIN_FULL[K_W-1:0];

endpackage

[rtl/core/spc_in_if.sv]
// beam item channel
`timescale 1ns / 1ps

interface spc_in_if;
	logic                         valid;
	logic                         ready;
	logic [spc_pkg::RANGE_W-1:0]  range;
	logic                         last_beam;

	modport source (output valid, output range, output last_beam, input ready);
	modport sink   (input valid, input range, input last_beam, output ready);
endinterface

[rtl/core/spc_out_if.sv]
// cartesian point item channel
`timescale 1ns / 1ps

interface spc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [spc_pkg::POINT_W-1:0]  point_x;
	logic signed [spc_pkg::POINT_W-1:0]  point_y;
	logic                                scan_end;

	modport source (output valid, output point_x, output point_y, output scan_end, input ready);
	modport sink   (input valid, input point_x, input point_y, input scan_end, output ready);
endinterface

[rtl/core/spc_cfg_if.sv]
// register write channel
`timescale 1ns / 1ps

interface spc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [spc_pkg::CFG_IDX_W-1:0]   index;
	logic [spc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/scan_polar_to_cartesian.sv]
// top level of the polar to cartesian scan converter
//
//   channel  dir  payload                          accepted when
//   cfg      in   index, data                      cfg.valid & cfg.ready
//   beam     in   range, last_beam                 beam.valid & beam.ready
//   point    out  point_x, point_y, scan_end       point.valid & point.ready
//
// a beam holds the block until its result is stored: the accepting cycle
// latches it, then come the range times gain product, the fold of the angle
// into the right half plane, cordic_steps rotations on the shared add/shift
// unit and the step that rounds and saturates into the result register.
// the next beam is taken as soon as the result is parked, even if the point
// channel is stalled; a second result waits in the rounding step until the
// parked one is taken.
// arst_n clears the sequencer, the angle offset and both angle registers.
`timescale 1ns / 1ps

module scan_polar_to_cartesian (
	input  logic      clk,
	input  logic      arst_n,
	spc_cfg_if.sink   cfg,
	spc_in_if.sink    beam,
	spc_out_if.source point
);

	// angle registers; write only while idle, the block does not enforce this
	logic [spc_pkg::ANG_IN_W-1:0] angle_start_q;
	logic [spc_pkg::ANG_IN_W-1:0] angle_step_q;

	spc_pkg::spc_cmd_t cmd;
	spc_pkg::spc_sts_t sts;

	// writes are always taken; unknown indexes fall through
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spc_pkg::REG_ANGLE_START: angle_start_q <= cfg.data;
				spc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer: owns the handshakes and the result valid flag
	spc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (beam.valid),
		.in_ready  (beam.ready),
		.out_valid (point.valid),
		.out_ready (point.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: running angle, gain scaling, rotations and result register
	spc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.angle_start (angle_start_q),
		.angle_step  (angle_step_q),
		.range       (beam.range),
		.last_beam   (beam.last_beam),
		.point_x     (point.point_x),
		.point_y     (point.point_y),
		.scan_end    (point.scan_end)
	);

endmodule

[rtl/core/spc_ctrl.sv]
// sequencing state machine for the scan converter
`timescale 1ns / 1ps

module spc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  spc_pkg::spc_sts_t sts,
	output spc_pkg::spc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_FOLD,
		S_ITER,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.mul   = (state_q == S_MUL);
		cmd.fold  = (state_q == S_FOLD);
		cmd.step  = (state_q == S_ITER);
		cmd.store = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL:  state_q <= S_FOLD;
				S_FOLD: state_q <= S_ITER;
				S_ITER: if (sts.step_last) state_q <= S_FIN;
				S_FIN:  if (cmd.store) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.store) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/spc_dp.sv]
// angle tracking, gain scaling and iterative cordic datapath
`timescale 1ns / 1ps

module spc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spc_pkg::spc_cmd_t                     cmd,
	output spc_pkg::spc_sts_t                     sts,
	input  logic [spc_pkg::ANG_IN_W-1:0]          angle_start,
	input  logic [spc_pkg::ANG_IN_W-1:0]          angle_step,
	input  logic [spc_pkg::RANGE_W-1:0]           range,
	input  logic                                  last_beam,
	output logic signed [spc_pkg::POINT_W-1:0]    point_x,
	output logic signed [spc_pkg::POINT_W-1:0]    point_y,
	output logic                                  scan_end
);

	localparam int XY_W  = spc_pkg::XY_W;
	localparam int Z_W   = spc_pkg::Z_W;
	localparam int PW    = spc_pkg::PROD_W;
	localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(1 << (spc_pkg::ANGLE_BITS - 2));
	localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(1 << (spc_pkg::ANGLE_BITS - 1));
	localparam logic signed [XY_W-1:0] RND_F    = XY_W'(1 << (spc_pkg::FRAC_BITS - 1));
	localparam logic signed [XY_W-1:0] SAT_HI   = XY_W'(spc_pkg::PT_MAX);
	localparam logic signed [XY_W-1:0] SAT_LO   = -SAT_HI;

	logic [spc_pkg::ANG_IN_W-1:0]      offset_q;
	logic [spc_pkg::CNT_W-1:0]         cnt_q;
	logic [spc_pkg::RANGE_W-1:0]       range_q;
	logic                              last_q;
	logic [PW-1:0]                     prod_q;
	logic signed [XY_W-1:0]            x_q;
	logic signed [XY_W-1:0]            y_q;
	logic signed [Z_W-1:0]             z_q;
	logic signed [spc_pkg::POINT_W-1:0] res_x_q;
	logic signed [spc_pkg::POINT_W-1:0] res_y_q;
	logic                              res_end_q;

	logic [spc_pkg::ANG_IN_W-1:0]      a16;
	logic [spc_pkg::PH_W-1:0]          ph_sum;
	logic [spc_pkg::PH_W-1:0]          ph_shift;
	logic [spc_pkg::ANGLE_BITS-1:0]    phase;
	logic signed [Z_W-1:0]             z_load;
	logic [PW:0]                       k_sum;
	logic [PW:0]                       k_shift;
	logic signed [XY_W-1:0]            x_init;
	logic signed [XY_W-1:0]            dx;
	logic signed [XY_W-1:0]            dy;
	logic signed [Z_W-1:0]             t_step;
	logic signed [XY_W-1:0]            x_rnd;
	logic signed [XY_W-1:0]            y_rnd;

	function automatic logic signed [spc_pkg::POINT_W-1:0] sat(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] c;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end else begin
			c = v;
		end
		return c[spc_pkg::POINT_W-1:0];
	endfunction

	// beam angle mapped to the working resolution, as a signed turn fraction
	assign a16      = angle_start + offset_q;
	assign ph_sum   = (spc_pkg::PH_W'(a16) << spc_pkg::SHIFT_UP)
	                  + spc_pkg::PH_W'(spc_pkg::HALF_DN);
	assign ph_shift = ph_sum >> spc_pkg::SHIFT_DN;
	assign phase    = ph_shift[spc_pkg::ANGLE_BITS-1:0];
	assign z_load   = Z_W'($signed(phase));

	// start vector length range*k in q20, rounded half up
	assign k_sum   = (PW + 1)'(prod_q) + (PW + 1)'(1 << (spc_pkg::SCALE_SH - 1));
	assign k_shift = k_sum >> spc_pkg::SCALE_SH;
	assign x_init  = $signed(XY_W'(k_shift));

	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign t_step = $signed(spc_pkg::atan_step(cnt_q));

	assign x_rnd = (x_q + RND_F) >>> spc_pkg::FRAC_BITS;
	assign y_rnd = (y_q + RND_F) >>> spc_pkg::FRAC_BITS;

	assign sts.step_last = (cnt_q == spc_pkg::CNT_W'(spc_pkg::CORDIC_STEPS - 1));

	assign point_x  = res_x_q;
	assign point_y  = res_y_q;
	assign scan_end = res_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.load) begin
				offset_q <= last_beam ? '0 : (offset_q + angle_step);
			end
			if (cmd.fold) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + spc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			range_q <= range;
			last_q  <= last_beam;
			z_q     <= z_load;
		end
		if (cmd.mul) begin
			prod_q <= PW'(range_q) * PW'(spc_pkg::GAIN_K);
		end
		if (cmd.fold) begin
			y_q <= '0;
			if (z_q > Z_QUARTER) begin
				z_q <= z_q - Z_HALF;
				x_q <= -x_init;
			end else if (z_q < -Z_QUARTER) begin
				z_q <= z_q + Z_HALF;
				x_q <= -x_init;
			end else begin
				x_q <= x_init;
			end
		end
		if (cmd.step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - t_step;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + t_step;
			end
		end
		if (cmd.store) begin
			res_x_q   <= sat(x_rnd);
			res_y_q   <= sat(y_rnd);
			res_end_q <= last_q;
		end
	end

endmodule

[rtl/core/spc_checker.sv]
// port-level checks for the scan converter, bound to the top level
`timescale 1ns / 1ps
`include "scan_polar_to_cartesian_macros.svh"

module spc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [spc_pkg::POINT_W-1:0] out_point_x,
	input logic signed [spc_pkg::POINT_W-1:0] out_point_y
);

	// a stalled result stays put
	`SPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_point_x) && $stable(out_point_y))

	// one beam at a time: no acceptance right after one
	`SPC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// a result never appears the cycle after an item is taken
	`SPC_ASSERT_IMPL(a_no_early_out, clk, arst_n, $rose(out_valid), !$past(in_valid && in_ready))

	// saturation keeps the coordinates off the most negative code
	`SPC_ASSERT_IMPL(a_sat_bound, clk, arst_n, out_valid, (out_point_x != 17'sh10000) && (out_point_y != 17'sh10000))

endmodule

bind scan_polar_to_cartesian spc_checker u_spc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (beam.valid),
	.in_ready    (beam.ready),
	.out_valid   (point.valid),
	.out_ready   (point.ready),
	.out_point_x (point.point_x),
	.out_point_y (point.point_y)
);
